// File: design/stkg_pkg.sv
// Shared types, constants and helpers for the stable three-key grouping block.
// No dependencies; every other file in the design folder imports this package.
package stkg_pkg;

   // Fixed field widths of one word
   localparam int NUMBER_W = 64;
   localparam int KEY_W    = 2;
   localparam int POS_W    = 10;
   localparam int TAG_W    = KEY_W + POS_W;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   // Default capacity of the data set
   localparam int SET_DEPTH_DEF = 1024;

   // Highest legal group key
   localparam logic [KEY_W-1:0] KEY_MAX = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_SPARE = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_OK    = 2'd0,
      RSP_FULL  = 2'd1,
      RSP_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_ORDER_RD,
      S_ORDER_WAIT,
      S_REPLY
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load_we;
      logic       clear;
      logic       res_plain;
      status_type res_status;
      logic       scan_init;
      logic       scan_step;
      logic       scan_done;
      logic       order_rd;
      logic       data_rd;
      logic       res_read;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic full;
      logic empty;
      logic order_ready;
      logic scan_end;
      logic out_free;
   } dp_status_type;

   // Key 3 is stored as key 2
   function automatic logic [KEY_W-1:0] key_sat(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] r;
      r = (k > KEY_MAX) ? KEY_MAX : k;
      return r;
   endfunction

endpackage

// File: design/stkg_ctrl.sv
// Controller state machine for the stable three-key grouping block.
// Depends on stkg_pkg; drives stkg_dpath only through command and status structs.
module stkg_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [stkg_pkg::CMD_W-1:0]    req_command,
   output logic                          req_stall,
   input  stkg_pkg::dp_status_type       stat,
   output stkg_pkg::dp_cmd_type          cmd
);
   import stkg_pkg::*;

   state_type state_ff;
   state_type state_in;
   cmd_type   cmd_kind;
   logic      accept;

   assign cmd_kind  = cmd_type'(req_command);
   assign req_stall = !((state_ff == S_IDLE) && stat.out_free);
   assign accept    = req_valid && !req_stall;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (cmd_kind == CMD_READ) && !stat.empty) begin
               state_in = stat.order_ready ? S_ORDER_RD : S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_end) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END:   state_in = S_ORDER_RD;
         S_ORDER_RD:   state_in = S_ORDER_WAIT;
         S_ORDER_WAIT: state_in = S_REPLY;
         S_REPLY: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:      state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd            = '0;
      cmd.res_status = RSP_OK;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (cmd_kind)
                  CMD_LOAD: begin
                     cmd.load_we    = !stat.full;
                     cmd.res_plain  = 1'b1;
                     cmd.res_status = stat.full ? RSP_FULL : RSP_OK;
                  end
                  CMD_READ: begin
                     if (stat.empty) begin
                        cmd.res_plain  = 1'b1;
                        cmd.res_status = RSP_EMPTY;
                     end else begin
                        cmd.scan_init = !stat.order_ready;
                     end
                  end
                  CMD_CLEAR: begin
                     cmd.clear     = 1'b1;
                     cmd.res_plain = 1'b1;
                  end
                  CMD_SPARE: begin
                     cmd.res_plain = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN:       cmd.scan_step = 1'b1;
         S_SCAN_END:   cmd.scan_done = 1'b1;
         S_ORDER_RD:   cmd.order_rd  = 1'b1;
         S_ORDER_WAIT: cmd.data_rd   = 1'b1;
         S_REPLY:      cmd.res_read  = stat.out_free;
         default: begin
            cmd.res_status = RSP_OK;
         end
      endcase
   end

endmodule

// File: design/stkg_dpath.sv
// Datapath of the stable three-key grouping block: item stores, order store,
// key counters, scatter pipeline and result register. Depends on stkg_pkg.
module stkg_dpath #(
   parameter int SET_DEPTH = stkg_pkg::SET_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stkg_pkg::dp_cmd_type                 cmd,
   output stkg_pkg::dp_status_type              stat,
   input  logic signed [stkg_pkg::NUMBER_W-1:0] req_item_number,
   input  logic [stkg_pkg::KEY_W-1:0]           req_item_key,
   input  logic [stkg_pkg::POS_W-1:0]           req_item_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [stkg_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [stkg_pkg::NUMBER_W-1:0] rsp_out_number,
   output logic [stkg_pkg::KEY_W-1:0]           rsp_out_key,
   output logic [stkg_pkg::POS_W-1:0]           rsp_out_position,
   output logic                                 rsp_is_last
);
   import stkg_pkg::*;

   localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int CNT_W = $clog2(SET_DEPTH + 1);

   // Storage
   logic [NUMBER_W-1:0] payload_mem [SET_DEPTH];
   logic [TAG_W-1:0]    tag_mem     [SET_DEPTH];
   logic [IDX_W-1:0]    order_mem   [SET_DEPTH];

   // Control state
   logic [CNT_W-1:0] cnt_ff [3];
   logic [CNT_W-1:0] cnt_in [3];
   logic [CNT_W-1:0] off_ff [3];
   logic [CNT_W-1:0] off_in [3];
   logic [CNT_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0] rp_ff, rp_in;
   logic             ready_ff, ready_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             wr_valid_ff, wr_valid_in;
   logic [IDX_W-1:0] wr_idx_ff;

   // Read data registers
   logic [NUMBER_W-1:0] pay_q_ff;
   logic [TAG_W-1:0]    tag_q_ff;
   logic [IDX_W-1:0]    ord_q_ff;

   // Result register
   logic                rsp_valid_ff;
   status_type          status_ff;
   logic [NUMBER_W-1:0] number_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                last_ff;

   logic [KEY_W-1:0] load_key;
   logic [KEY_W-1:0] wr_key;
   logic [CNT_W-1:0] off_sel;
   logic [CNT_W-1:0] rp_next;
   logic             rd_last;
   logic [IDX_W-1:0] tag_addr;
   logic [IDX_W-1:0] total_idx;

   assign load_key  = key_sat(req_item_key);
   assign wr_key    = tag_q_ff[TAG_W-1 -: KEY_W];
   assign off_sel   = off_ff[wr_key];
   assign rp_next   = CNT_W'(rp_ff) + CNT_W'(1);
   assign rd_last   = (rp_next == total_ff);
   assign tag_addr  = cmd.scan_step ? scan_idx_ff : ord_q_ff;
   assign total_idx = total_ff[IDX_W-1:0];

   // Status to the controller
   assign stat.full        = (total_ff == CNT_W'(SET_DEPTH));
   assign stat.empty       = (total_ff == '0);
   assign stat.order_ready = ready_ff;
   assign stat.scan_end    = (CNT_W'(scan_idx_ff) == (total_ff - CNT_W'(1)));
   assign stat.out_free    = !rsp_valid_ff || !rsp_stall;

   // Next values of counters, offsets and pointers
   always_comb begin
      cnt_in      = cnt_ff;
      off_in      = off_ff;
      total_in    = total_ff;
      rp_in       = rp_ff;
      ready_in    = ready_ff;
      scan_idx_in = scan_idx_ff;
      wr_valid_in = cmd.scan_step;
      if (cmd.clear) begin
         cnt_in[0] = '0;
         cnt_in[1] = '0;
         cnt_in[2] = '0;
         total_in  = '0;
         rp_in     = '0;
         ready_in  = 1'b0;
      end
      if (cmd.load_we) begin
         cnt_in[load_key] = cnt_ff[load_key] + CNT_W'(1);
         total_in         = total_ff + CNT_W'(1);
         rp_in            = '0;
         ready_in         = 1'b0;
      end
      if (cmd.scan_init) begin
         scan_idx_in = '0;
         off_in[0]   = '0;
         off_in[1]   = cnt_ff[0];
         off_in[2]   = cnt_ff[0] + cnt_ff[1];
      end
      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff + IDX_W'(1);
      end
      if (wr_valid_ff) begin
         off_in[wr_key] = off_sel + CNT_W'(1);
      end
      if (cmd.scan_done) begin
         ready_in = 1'b1;
         rp_in    = '0;
      end
      if (cmd.res_read) begin
         rp_in = rd_last ? '0 : rp_next[IDX_W-1:0];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff[0]   <= '0;
         cnt_ff[1]   <= '0;
         cnt_ff[2]   <= '0;
         off_ff[0]   <= '0;
         off_ff[1]   <= '0;
         off_ff[2]   <= '0;
         total_ff    <= '0;
         rp_ff       <= '0;
         ready_ff    <= 1'b0;
         scan_idx_ff <= '0;
         wr_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         off_ff      <= off_in;
         total_ff    <= total_in;
         rp_ff       <= rp_in;
         ready_ff    <= ready_in;
         scan_idx_ff <= scan_idx_in;
         wr_valid_ff <= wr_valid_in;
      end
   end

   // Item stores: written on load, read during scatter and on fetch
   always_ff @(posedge clock) begin
      if (cmd.load_we) begin
         payload_mem[total_idx] <= req_item_number;
         tag_mem[total_idx]     <= {load_key, req_item_position};
      end
      if (cmd.data_rd) begin
         pay_q_ff <= payload_mem[ord_q_ff];
      end
      if (cmd.scan_step || cmd.data_rd) begin
         tag_q_ff <= tag_mem[tag_addr];
      end
      if (cmd.scan_step) begin
         wr_idx_ff <= scan_idx_ff;
      end
   end

   // Order store: scatter writes at the running key offset
   always_ff @(posedge clock) begin
      if (wr_valid_ff) begin
         order_mem[off_sel[IDX_W-1:0]] <= wr_idx_ff;
      end
      if (cmd.order_rd) begin
         ord_q_ff <= order_mem[rp_ff];
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.res_plain || cmd.res_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result register word
   always_ff @(posedge clock) begin
      if (cmd.res_plain) begin
         status_ff <= cmd.res_status;
         number_ff <= '0;
         key_ff    <= '0;
         pos_ff    <= '0;
         last_ff   <= 1'b0;
      end else if (cmd.res_read) begin
         status_ff <= RSP_OK;
         number_ff <= pay_q_ff;
         key_ff    <= tag_q_ff[TAG_W-1 -: KEY_W];
         pos_ff    <= tag_q_ff[POS_W-1:0];
         last_ff   <= rd_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_number   = number_ff;
   assign rsp_out_key      = key_ff;
   assign rsp_out_position = pos_ff;
   assign rsp_is_last      = last_ff;

   // Per-key counts always add up to the item total
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      ({2'b00, cnt_ff[0]} + {2'b00, cnt_ff[1]} + {2'b00, cnt_ff[2]}) == {2'b00, total_ff})
      else $error("key counts disagree with item total");

   // Scatter never writes past the loaded set
   a_scatter_bound: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> (off_sel < total_ff))
      else $error("scatter slot beyond item total");

   // Read pointer stays inside a non-empty set
   a_rp_bound: assert property (@(posedge clock) disable iff (reset)
      (total_ff != '0) |-> (CNT_W'(rp_ff) < total_ff))
      else $error("read pointer beyond item total");

   // A new result is only loaded when the result register can take it
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.res_plain || cmd.res_read) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

endmodule

// File: design/stable_three_key_grouping_top.sv
// Top level of the stable three-key grouping block (stable counting sort, keys 0..2).
// Depends on stkg_pkg, stkg_ctrl and stkg_dpath.
//
//   Channel  Direction  Handshake             Word
//   req      in         req_valid/req_stall   command, item number, key, position
//   rsp      out        rsp_valid/rsp_stall   status, number, key, position, is_last
//
// Load, clear, unused command and read of an empty set: the result is
// registered at the accept edge.
// Read: passes through the order store and then the item stores, each a
// single-port memory with registered read data. The first read after any load
// adds a scatter pass over all loaded items.
// Reset is synchronous; the stores hold nothing valid until written.
// A stalled result holds in the output register; a new word is taken only
// when that register is free or being drained in the same cycle.
module stable_three_key_grouping_top #(
   parameter int SET_DEPTH = stkg_pkg::SET_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [stkg_pkg::CMD_W-1:0]           req_command,
   input  logic signed [stkg_pkg::NUMBER_W-1:0] req_item_number,
   input  logic [stkg_pkg::KEY_W-1:0]           req_item_key,
   input  logic [stkg_pkg::POS_W-1:0]           req_item_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [stkg_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [stkg_pkg::NUMBER_W-1:0] rsp_out_number,
   output logic [stkg_pkg::KEY_W-1:0]           rsp_out_key,
   output logic [stkg_pkg::POS_W-1:0]           rsp_out_position,
   output logic                                 rsp_is_last
);
   import stkg_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_stat;

   // Sequencer
   stkg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .stat        (dp_stat),
      .cmd         (dp_cmd)
   );

   // Stores, counters and result register
   stkg_dpath #(
      .SET_DEPTH (SET_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .stat              (dp_stat),
      .req_item_number   (req_item_number),
      .req_item_key      (req_item_key),
      .req_item_position (req_item_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_number    (rsp_out_number),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_position  (rsp_out_position),
      .rsp_is_last       (rsp_is_last)
   );

endmodule
